/* src/first_quadrant_angle_degrees_top_defines.svh */
// Assertion macros used by the checker file.
`ifndef FIRST_QUADRANT_ANGLE_DEGREES_TOP_DEFINES_SVH
`define FIRST_QUADRANT_ANGLE_DEGREES_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FQAD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FQAD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/fqad_pkg.sv */
`timescale 1ns / 1ps
package fqad_pkg;

  localparam int FIELD_W          = 16;
  localparam int COORD_WIDTH_DEF  = 16;
  localparam int ITERATIONS_DEF   = 16;
  localparam int GUARD_BITS       = 24;
  localparam int TABLE_LEN        = 24;

  // angle accumulator, degrees Q.16, signed
  localparam int ZW     = 25;
  localparam int MAG_W  = ZW - 1;
  // folded angle, 0..90 degrees Q.16
  localparam int ANG_W  = 23;
  // rounded angle, Q8.9 before the final clamp
  localparam int Q9_W   = ANG_W + 1 - 7;

  localparam logic [ANG_W-1:0] DEG45_Q16    = ANG_W'(2949120);
  localparam logic [ANG_W-1:0] DEG90_Q16    = ANG_W'(5898240);
  localparam logic [ANG_W-1:0] ROUND_HALF   = ANG_W'(64);
  localparam logic [Q9_W-1:0]  ANGLE_MAX_Q9 = Q9_W'(46080);

  typedef struct packed {
    logic upper;   // y >= x: result is 90 minus the octant angle
    logic origin;  // both coordinates zero
  } fqad_ctrl_t;

  // round(atan(2^-i) * 180 / pi * 65536)
  function automatic logic [MAG_W-1:0] atan_q16(input int unsigned idx);
    logic [MAG_W-1:0] v;
    case (idx)
      0:       v = MAG_W'(2949120);
      1:       v = MAG_W'(1740967);
      2:       v = MAG_W'(919879);
      3:       v = MAG_W'(466945);
      4:       v = MAG_W'(234379);
      5:       v = MAG_W'(117304);
      6:       v = MAG_W'(58666);
      7:       v = MAG_W'(29335);
      8:       v = MAG_W'(14668);
      9:       v = MAG_W'(7334);
      10:      v = MAG_W'(3667);
      11:      v = MAG_W'(1833);
      12:      v = MAG_W'(917);
      13:      v = MAG_W'(458);
      14:      v = MAG_W'(229);
      15:      v = MAG_W'(115);
      16:      v = MAG_W'(57);
      17:      v = MAG_W'(29);
      18:      v = MAG_W'(14);
      19:      v = MAG_W'(7);
      20:      v = MAG_W'(4);
      21:      v = MAG_W'(2);
      22:      v = MAG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* src/fqad_prep.sv */
`timescale 1ns / 1ps
// Input stage: mask, octant fold, scale into the CORDIC vector.
module fqad_prep
  import fqad_pkg::*;
#(
  parameter int CWE = 16,
  parameter int W   = CWE + GUARD_BITS + 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_in,
  output logic                ready_in,
  input  logic [FIELD_W-1:0]  x_in,
  input  logic [FIELD_W-1:0]  y_in,
  output logic                valid_out,
  input  logic                ready_out,
  output logic signed [W-1:0] a_out,
  output logic signed [W-1:0] b_out,
  output logic signed [ZW-1:0] z_out,
  output fqad_ctrl_t          ctrl_out
);

  logic [CWE-1:0]       x_m, y_m, long_side, short_side;
  logic                 valid_r;
  logic signed [W-1:0]  a_r, b_r, a_nxt, b_nxt;
  fqad_ctrl_t           ctrl_r, ctrl_nxt;

  assign ready_in = !valid_r || ready_out;

  always_comb begin
    x_m             = x_in[CWE-1:0];
    y_m             = y_in[CWE-1:0];
    ctrl_nxt.upper  = !(y_m < x_m);
    ctrl_nxt.origin = (x_m == '0) && (y_m == '0);
    long_side       = ctrl_nxt.upper ? y_m : x_m;
    short_side      = ctrl_nxt.upper ? x_m : y_m;
    a_nxt           = signed'({3'b000, long_side, {GUARD_BITS{1'b0}}});
    b_nxt           = signed'({3'b000, short_side, {GUARD_BITS{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_in) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && valid_in) begin
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      ctrl_r <= ctrl_nxt;
    end
  end

  assign valid_out = valid_r;
  assign a_out     = a_r;
  assign b_out     = b_r;
  assign z_out     = '0;
  assign ctrl_out  = ctrl_r;

endmodule

/* src/fqad_cordic_stage.sv */
`timescale 1ns / 1ps
// One vectoring CORDIC micro-rotation, registered.
module fqad_cordic_stage
  import fqad_pkg::*;
#(
  parameter int W     = 43,
  parameter int STAGE = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_in,
  output logic                 ready_in,
  input  logic signed [W-1:0]  a_in,
  input  logic signed [W-1:0]  b_in,
  input  logic signed [ZW-1:0] z_in,
  input  fqad_ctrl_t           ctrl_in,
  output logic                 valid_out,
  input  logic                 ready_out,
  output logic signed [W-1:0]  a_out,
  output logic signed [W-1:0]  b_out,
  output logic signed [ZW-1:0] z_out,
  output fqad_ctrl_t           ctrl_out
);

  logic                 valid_r;
  logic signed [W-1:0]  da, db, a_r, b_r, a_nxt, b_nxt;
  logic signed [ZW-1:0] zt, z_r, z_nxt;
  fqad_ctrl_t           ctrl_r;

  assign ready_in = !valid_r || ready_out;

  always_comb begin
    da = b_in >>> STAGE;
    db = a_in >>> STAGE;
    zt = signed'({1'b0, atan_q16(STAGE)});
    if (!b_in[W-1]) begin
      a_nxt = a_in + da;
      b_nxt = b_in - db;
      z_nxt = z_in + zt;
    end else begin
      a_nxt = a_in - da;
      b_nxt = b_in + db;
      z_nxt = z_in - zt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_in) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && valid_in) begin
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      z_r    <= z_nxt;
      ctrl_r <= ctrl_in;
    end
  end

  assign valid_out = valid_r;
  assign a_out     = a_r;
  assign b_out     = b_r;
  assign z_out     = z_r;
  assign ctrl_out  = ctrl_r;

endmodule

/* src/fqad_post.sv */
`timescale 1ns / 1ps
// Output stage: clamp, mirror, round to Q7.9; holds the result register.
module fqad_post
  import fqad_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_in,
  output logic                 ready_in,
  input  logic signed [ZW-1:0] z_in,
  input  fqad_ctrl_t           ctrl_in,
  output logic                 valid_out,
  input  logic                 ready_out,
  output logic [FIELD_W-1:0]   angle_out,
  output logic                 undef_out
);

  logic [MAG_W-1:0]   z_mag;
  logic [ANG_W-1:0]   oct, ang;
  logic [ANG_W:0]     rsum;
  logic [Q9_W-1:0]    q9;
  logic [FIELD_W-1:0] angle_r, angle_nxt;
  logic               undef_r, valid_r;

  assign ready_in = !valid_r || ready_out;

  always_comb begin
    z_mag = z_in[MAG_W-1:0];
    priority if (z_in[ZW-1]) begin
      oct = '0;
    end else if (z_mag > MAG_W'(DEG45_Q16)) begin
      oct = DEG45_Q16;
    end else begin
      oct = z_mag[ANG_W-1:0];
    end
    ang  = ctrl_in.upper ? (DEG90_Q16 - oct) : oct;
    rsum = {1'b0, ang} + {1'b0, ROUND_HALF};
    q9   = rsum[ANG_W:7];
    if (ctrl_in.origin) begin
      angle_nxt = '0;
    end else if (q9 > ANGLE_MAX_Q9) begin
      angle_nxt = ANGLE_MAX_Q9[FIELD_W-1:0];
    end else begin
      angle_nxt = q9[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_in) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && valid_in) begin
      angle_r <= angle_nxt;
      undef_r <= ctrl_in.origin;
    end
  end

  assign valid_out = valid_r;
  assign angle_out = angle_r;
  assign undef_out = undef_r;

endmodule

/* src/first_quadrant_angle_degrees_top.sv */
`timescale 1ns / 1ps
// First-quadrant angle: takes an unsigned (x, y) point and returns its angle from the
// x axis in degrees, 0.0 to 90.0, as unsigned Q7.9 (46080 = 90.0). The point is folded
// into the octant below 45 degrees, atan(small/large) is found by ITERATIONS unrolled
// vectoring CORDIC stages with a degree-valued angle table, and the result is mirrored
// for the upper octant (equal coordinates give 45.0). The origin gives angle 0 with the
// undefined flag set. Only the low COORD_WIDTH bits of each coordinate are used (at
// most 16). One item enters per clock while in_tready is high; the items pass an input
// fold stage, one stage per CORDIC iteration and a rounding stage that is also the output
// register. Every stage has its own valid bit and takes a new item whenever it is
// empty or its successor takes its content, so empty slots fill up behind a stalled
// output and out_tready back-pressure reaches in_tready only once the pipe is full.
module first_quadrant_angle_degrees_top
  import fqad_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,  // 8..32
  parameter int ITERATIONS  = ITERATIONS_DEF    // 8..24, limited by the angle table
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [2*FIELD_W-1:0] in_tdata,   // [15:0] x_coord, [31:16] y_coord
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [FIELD_W-1:0]   out_tdata,  // [15:0] angle_deg
  output logic [0:0]           out_tuser   // [0] undefined
);

  // coordinate bits actually used
  localparam int CWE = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
  // vector width: guard bits plus CORDIC growth and sign
  localparam int W   = CWE + GUARD_BITS + 3;

  // index k: output of the fold stage (k = 0) or of CORDIC stage k-1
  logic                 v_s   [0:ITERATIONS];
  logic                 rdy_s [0:ITERATIONS];
  logic signed [W-1:0]  a_s   [0:ITERATIONS];
  logic signed [W-1:0]  b_s   [0:ITERATIONS];
  logic signed [ZW-1:0] z_s   [0:ITERATIONS];
  fqad_ctrl_t           c_s   [0:ITERATIONS];

  fqad_prep #(
    .CWE (CWE),
    .W   (W)
  ) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (in_tvalid),
    .ready_in  (in_tready),
    .x_in      (in_tdata[FIELD_W-1:0]),
    .y_in      (in_tdata[2*FIELD_W-1:FIELD_W]),
    .valid_out (v_s[0]),
    .ready_out (rdy_s[0]),
    .a_out     (a_s[0]),
    .b_out     (b_s[0]),
    .z_out     (z_s[0]),
    .ctrl_out  (c_s[0])
  );

  for (genvar k = 0; k < ITERATIONS; k++) begin : g_cordic
    fqad_cordic_stage #(
      .W     (W),
      .STAGE (k)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_in  (v_s[k]),
      .ready_in  (rdy_s[k]),
      .a_in      (a_s[k]),
      .b_in      (b_s[k]),
      .z_in      (z_s[k]),
      .ctrl_in   (c_s[k]),
      .valid_out (v_s[k+1]),
      .ready_out (rdy_s[k+1]),
      .a_out     (a_s[k+1]),
      .b_out     (b_s[k+1]),
      .z_out     (z_s[k+1]),
      .ctrl_out  (c_s[k+1])
    );
  end

  // final vector components are not needed; only the angle goes on
  fqad_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (v_s[ITERATIONS]),
    .ready_in  (rdy_s[ITERATIONS]),
    .z_in      (z_s[ITERATIONS]),
    .ctrl_in   (c_s[ITERATIONS]),
    .valid_out (out_tvalid),
    .ready_out (out_tready),
    .angle_out (out_tdata),
    .undef_out (out_tuser[0])
  );

endmodule

/* src/fqad_checker.sv */
`timescale 1ns / 1ps
`include "first_quadrant_angle_degrees_top_defines.svh"
// Port-level checks on the result channel.
module fqad_checker
  import fqad_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [FIELD_W-1:0]   out_tdata,
  input logic [0:0]           out_tuser
);

  `FQAD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `FQAD_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `FQAD_ASSERT_NOW(a_origin_zero, out_tvalid && out_tuser[0], out_tdata == '0, "origin with nonzero angle")
  `FQAD_ASSERT_NOW(a_angle_range, out_tvalid, out_tdata <= FIELD_W'(ANGLE_MAX_Q9), "angle above 90 degrees")

endmodule

bind first_quadrant_angle_degrees_top fqad_checker u_fqad_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
